// File: rtl/core/askpfd_pkg.sv
// Shared types, constants and register indexes for the ASK pulse frame decoder.
// Depends on nothing; every other file of the block refers to it by scoped names.
package askpfd_pkg;

	localparam int TICK_W     = 8;
	localparam int HOST_W     = 8;
	localparam int NIBBLE_W   = 4;
	localparam int LEVEL_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam int FRAME_BITS_DEF = 24;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOST_ADDRESS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 3'd5;

	// Register values after reset.
	localparam logic [TICK_W-1:0]   SHORT_MIN_RST      = 8'd4;
	localparam logic [TICK_W-1:0]   SHORT_MAX_RST      = 8'd14;
	localparam logic [TICK_W-1:0]   LONG_MIN_RST       = 8'd16;
	localparam logic [TICK_W-1:0]   LONG_MAX_RST       = 8'd60;
	localparam logic [HOST_W-1:0]   HOST_ADDRESS_RST   = 8'd120;
	localparam logic [NIBBLE_W-1:0] DEVICE_ADDRESS_RST = 4'd1;

	// Class of one pulse: length and the level it had.
	typedef enum logic [1:0] {
		PULSE_SHORT_LOW  = 2'd0,
		PULSE_SHORT_HIGH = 2'd1,
		PULSE_LONG_LOW   = 2'd2,
		PULSE_LONG_HIGH  = 2'd3
	} pulse_code_t;

	typedef struct packed {
		logic [TICK_W-1:0] short_min;
		logic [TICK_W-1:0] short_max;
		logic [TICK_W-1:0] long_min;
		logic [TICK_W-1:0] long_max;
	} window_t;

	typedef struct packed {
		logic        valid;
		pulse_code_t code;
	} pulse_class_t;

endpackage

// File: rtl/core/askpfd_if.sv
// Handshake channel interfaces of the ASK pulse frame decoder: pulse edges in,
// decoded frames out, and the configuration write channel. Depends on askpfd_pkg.
interface askpfd_pulse_if;
	logic                            valid;
	logic                            ready;
	logic                            new_level;
	logic [askpfd_pkg::TICK_W-1:0]   pulse_ticks;
	logic                            timeout;

	modport source (output valid, new_level, pulse_ticks, timeout, input ready);
	modport sink   (input valid, new_level, pulse_ticks, timeout, output ready);
endinterface

interface askpfd_frame_if;
	logic                            valid;
	logic                            ready;
	logic [askpfd_pkg::HOST_W-1:0]   frame_host;
	logic [askpfd_pkg::NIBBLE_W-1:0] frame_device;
	logic [askpfd_pkg::NIBBLE_W-1:0] frame_mode;
	logic [askpfd_pkg::LEVEL_W-1:0]  frame_level;
	logic                            address_match;
	logic [askpfd_pkg::NIBBLE_W-1:0] action_mode;
	logic [askpfd_pkg::LEVEL_W-1:0]  action_level;

	modport source (output valid, frame_host, frame_device, frame_mode, frame_level,
		address_match, action_mode, action_level, input ready);
	modport sink   (input valid, frame_host, frame_device, frame_mode, frame_level,
		address_match, action_mode, action_level, output ready);
endinterface

interface askpfd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [askpfd_pkg::CFG_IDX_W-1:0]  index;
	logic [askpfd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/askpfd_classify.sv
// Pulse classifier: sorts one pulse into short or long by exclusive tick windows.
// Depends on askpfd_pkg for the window and class types.
module askpfd_classify (
	input  logic                          new_level,
	input  logic [askpfd_pkg::TICK_W-1:0] pulse_ticks,
	input  logic                          timeout,
	input  askpfd_pkg::window_t           win,
	output askpfd_pkg::pulse_class_t      pclass
);

	logic is_short;
	logic is_long;

	assign is_short = (pulse_ticks > win.short_min) && (pulse_ticks < win.short_max);
	assign is_long  = (pulse_ticks > win.long_min) && (pulse_ticks < win.long_max);

	// The short window wins when the two overlap. A high new level means the
	// pulse that just ended was low.
	always_comb begin
		pclass.valid = !timeout && (is_short || is_long);
		if (is_short) begin
			pclass.code = new_level ? askpfd_pkg::PULSE_SHORT_LOW
				: askpfd_pkg::PULSE_SHORT_HIGH;
		end else begin
			pclass.code = new_level ? askpfd_pkg::PULSE_LONG_LOW
				: askpfd_pkg::PULSE_LONG_HIGH;
		end
	end

endmodule

// File: rtl/core/ask_pulse_frame_decoder.sv
// ASK pulse frame decoder, top level. Depends on askpfd_pkg, askpfd_if, askpfd_classify.
// Throughput: one pulse edge per clock cycle while the input is not stalled, set by the
// single pass through the classifier, pair check and frame shift register between the input
// and result registers. The last edge of a frame is held in the input register and its result
// then loads into the result register; the input stalls only while a result waits and the held
// edge would finish another frame. Reset (arst_n low): state clears, registers take defaults.
module ask_pulse_frame_decoder #(
	parameter int FRAME_BITS = askpfd_pkg::FRAME_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	askpfd_pulse_if.sink    pulse,
	askpfd_frame_if.source  frame,
	askpfd_cfg_if.sink      cfg
);

	localparam int CNT_W = $clog2(FRAME_BITS + 1);

	// Configuration registers.
	askpfd_pkg::window_t                win_q;
	logic [askpfd_pkg::HOST_W-1:0]      host_address_q;
	logic [askpfd_pkg::NIBBLE_W-1:0]    device_address_q;

	// Input stage: one pulse edge held for the decode pass.
	logic                               valid_s1;
	logic                               new_level_s1;
	logic [askpfd_pkg::TICK_W-1:0]      pulse_ticks_s1;
	logic                               timeout_s1;

	// Decoder state.
	askpfd_pkg::pulse_code_t            first_code_q;
	logic                               half_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic [FRAME_BITS-1:0]              shift_q;
	logic [askpfd_pkg::NIBBLE_W-1:0]    stored_mode_q;
	logic [askpfd_pkg::LEVEL_W-1:0]     stored_level_q;

	// Result register.
	logic                               res_valid_q;

	askpfd_pkg::pulse_class_t           pclass;
	logic                               adv;
	logic                               step;
	logic                               bit_ok;
	logic                               bit_val;
	logic [CNT_W-1:0]                   cnt_inc;
	logic                               frame_done;
	logic                               load_res;
	logic [FRAME_BITS-1:0]              shift_next;
	logic [askpfd_pkg::HOST_W-1:0]      host_w;
	logic [askpfd_pkg::NIBBLE_W-1:0]    dev_w;
	logic [askpfd_pkg::NIBBLE_W-1:0]    mode_w;
	logic [askpfd_pkg::LEVEL_W-1:0]     level_w;
	logic                               match_w;

	// The decode stage moves whenever the result register is free or being
	// drained. An edge that finishes no frame moves even while a finished frame
	// waits, so only an edge that would finish a second frame stalls the input.
	assign adv         = !res_valid_q || frame.ready || !frame_done;
	assign pulse.ready = !valid_s1 || adv;
	assign step        = valid_s1 && adv;

	// The user must write configuration only while the decoder is idle; the block does not enforce it.
	assign cfg.ready = 1'b1;

	askpfd_classify u_classify (
		.new_level   (new_level_s1),
		.pulse_ticks (pulse_ticks_s1),
		.timeout     (timeout_s1),
		.win         (win_q),
		.pclass      (pclass)
	);

	// A data bit is short high then long low (zero) or long high then short low (one).
	always_comb begin
		bit_ok  = 1'b0;
		bit_val = 1'b0;
		if (first_code_q == askpfd_pkg::PULSE_SHORT_HIGH
				&& pclass.code == askpfd_pkg::PULSE_LONG_LOW) begin
			bit_ok = 1'b1;
		end else if (first_code_q == askpfd_pkg::PULSE_LONG_HIGH
				&& pclass.code == askpfd_pkg::PULSE_SHORT_LOW) begin
			bit_ok  = 1'b1;
			bit_val = 1'b1;
		end
	end

	assign shift_next = {shift_q[FRAME_BITS-2:0], bit_val};
	assign cnt_inc    = cnt_q + CNT_W'(1);
	assign frame_done = pclass.valid && half_q && bit_ok && (cnt_inc == CNT_W'(FRAME_BITS));
	assign load_res   = step && frame_done;

	// The first 24 bits of the frame, oldest first, carry host, device, mode and level.
	assign host_w  = shift_next[FRAME_BITS-1:FRAME_BITS-8];
	assign dev_w   = shift_next[FRAME_BITS-9:FRAME_BITS-12];
	assign mode_w  = shift_next[FRAME_BITS-13:FRAME_BITS-16];
	assign level_w = shift_next[FRAME_BITS-17:FRAME_BITS-24];
	assign match_w = (host_w == host_address_q) && (dev_w == device_address_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.short_min  <= askpfd_pkg::SHORT_MIN_RST;
			win_q.short_max  <= askpfd_pkg::SHORT_MAX_RST;
			win_q.long_min   <= askpfd_pkg::LONG_MIN_RST;
			win_q.long_max   <= askpfd_pkg::LONG_MAX_RST;
			host_address_q   <= askpfd_pkg::HOST_ADDRESS_RST;
			device_address_q <= askpfd_pkg::DEVICE_ADDRESS_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				askpfd_pkg::REG_SHORT_MIN:      win_q.short_min  <= cfg.data;
				askpfd_pkg::REG_SHORT_MAX:      win_q.short_max  <= cfg.data;
				askpfd_pkg::REG_LONG_MIN:       win_q.long_min   <= cfg.data;
				askpfd_pkg::REG_LONG_MAX:       win_q.long_max   <= cfg.data;
				askpfd_pkg::REG_HOST_ADDRESS:   host_address_q   <= cfg.data;
				askpfd_pkg::REG_DEVICE_ADDRESS: device_address_q <= cfg.data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pulse.ready) begin
			valid_s1 <= pulse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pulse.valid && pulse.ready) begin
			new_level_s1   <= pulse.new_level;
			pulse_ticks_s1 <= pulse.pulse_ticks;
			timeout_s1     <= pulse.timeout;
		end
	end

	// Pair and frame state. A timeout, a pulse outside both windows or a
	// pair that is not a data bit drops the partial frame. The shift
	// register keeps stale bits; only the last FRAME_BITS ever matter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_code_q   <= askpfd_pkg::PULSE_SHORT_LOW;
			half_q         <= 1'b0;
			cnt_q          <= '0;
			shift_q        <= '0;
			stored_mode_q  <= '0;
			stored_level_q <= '0;
		end else if (step) begin
			if (!pclass.valid) begin
				half_q <= 1'b0;
				cnt_q  <= '0;
			end else if (!half_q) begin
				first_code_q <= pclass.code;
				half_q       <= 1'b1;
			end else if (!bit_ok) begin
				half_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				half_q  <= 1'b0;
				shift_q <= shift_next;
				if (frame_done) begin
					cnt_q <= '0;
					if (match_w) begin
						stored_mode_q  <= mode_w;
						stored_level_q <= level_w;
					end
				end else begin
					cnt_q <= cnt_inc;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (frame.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			frame.frame_host    <= host_w;
			frame.frame_device  <= dev_w;
			frame.frame_mode    <= mode_w;
			frame.frame_level   <= level_w;
			frame.address_match <= match_w;
			frame.action_mode   <= match_w ? mode_w : stored_mode_q;
			frame.action_level  <= match_w ? level_w : stored_level_q;
		end
	end

	assign frame.valid = res_valid_q;

	// The bit counter wraps to zero at the frame length and never holds it.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(FRAME_BITS))
		else $error("bit counter reached the frame length");

	// A matching frame reports the action it has just stored.
	a_match_action: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.address_match) |->
		(frame.action_mode == frame.frame_mode && frame.action_level == frame.frame_level))
		else $error("matching frame does not report its own action");

	// A timed-out edge drops any partial bit and frame.
	a_timeout_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && timeout_s1) |=> (!half_q && cnt_q == '0))
		else $error("timeout did not clear the pair and bit counts");

	// The stored action changes only when a frame result is loaded.
	a_store_on_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(stored_mode_q != $past(stored_mode_q) || stored_level_q != $past(stored_level_q))
		|-> $past(load_res))
		else $error("stored action changed without a completed frame");

endmodule

// File: tb/ask_pulse_frame_decoder_tb.sv
// Self-checking testbench for the ASK pulse frame decoder: pulse edges go in through
// the pulse channel and every decoded frame is checked against a behavioral decoder.
// Depends on askpfd_pkg, the askpfd channel interfaces and the ask_pulse_frame_decoder RTL.
`timescale 1ns / 100ps

module ask_pulse_frame_decoder_tb;

	localparam int FRAME_BITS  = askpfd_pkg::FRAME_BITS_DEF;
	localparam int CLK_HALF    = 4;
	localparam int RESET_CYCLES = 10;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	// Indexes beyond the last register; writes to them must change nothing.
	localparam logic [askpfd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [askpfd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Class of a tick count under the current windows.
	typedef enum logic [1:0] {
		TICK_NONE,
		TICK_SHORT,
		TICK_LONG
	} tick_class_t;

	// One decoded frame as it leaves the block.
	typedef struct packed {
		logic [askpfd_pkg::HOST_W-1:0]   host;
		logic [askpfd_pkg::NIBBLE_W-1:0] device;
		logic [askpfd_pkg::NIBBLE_W-1:0] mode;
		logic [askpfd_pkg::LEVEL_W-1:0]  level;
		logic                            match;
		logic [askpfd_pkg::NIBBLE_W-1:0] act_mode;
		logic [askpfd_pkg::LEVEL_W-1:0]  act_level;
	} frame_result_t;

	logic clk;
	logic arst_n;

	askpfd_pulse_if pulse_ch();
	askpfd_frame_if frame_ch();
	askpfd_cfg_if   cfg_ch();

	ask_pulse_frame_decoder #(
		.FRAME_BITS(FRAME_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pulse  (pulse_ch),
		.frame  (frame_ch),
		.cfg    (cfg_ch)
	);

	// Register copy held by the decoder below.
	askpfd_pkg::window_t             win;
	logic [askpfd_pkg::HOST_W-1:0]   host_addr;
	logic [askpfd_pkg::NIBBLE_W-1:0] dev_addr;

	// Decoder state: the held first half of a bit, the bit count, the shift register
	// and the stored action.
	askpfd_pkg::pulse_code_t         first_code;
	logic                            pair_held;
	logic [5:0]                      bits_seen;
	logic [39:0]                     shift_reg;
	logic [askpfd_pkg::NIBBLE_W-1:0] act_mode;
	logic [askpfd_pkg::LEVEL_W-1:0]  act_level;

	// Frames that the decoder has produced and the block has not yet delivered.
	frame_result_t pending_frames[$];
	frame_result_t want;

	int errors;
	int edges_sent;
	int cycle_count;
	int gap_pct;
	int stall_pct;
	int hold_left;

	// The clock runs freely from time zero.
	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Watchdog: a run that hangs anywhere ends here as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d frames still expected", $time,
				pending_frames.size());
			$display("ask_pulse_frame_decoder_tb NOT OK");
			$finish;
		end
	end

	// Register state after reset, taken from the package defaults, and cleared decoder state.
	function automatic void reset_decoder();
		win.short_min = askpfd_pkg::SHORT_MIN_RST;
		win.short_max = askpfd_pkg::SHORT_MAX_RST;
		win.long_min  = askpfd_pkg::LONG_MIN_RST;
		win.long_max  = askpfd_pkg::LONG_MAX_RST;
		host_addr     = askpfd_pkg::HOST_ADDRESS_RST;
		dev_addr      = askpfd_pkg::DEVICE_ADDRESS_RST;
		first_code    = askpfd_pkg::PULSE_SHORT_LOW;
		pair_held     = 1'b0;
		bits_seen     = '0;
		shift_reg     = '0;
		act_mode      = '0;
		act_level     = '0;
	endfunction

	// The short window is tested first, so an overlap counts as short.
	function automatic tick_class_t tick_class(input logic [askpfd_pkg::TICK_W-1:0] t);
		if (t > win.short_min && t < win.short_max)
			return TICK_SHORT;
		if (t > win.long_min && t < win.long_max)
			return TICK_LONG;
		return TICK_NONE;
	endfunction

	// Applies one edge to the decoder state and queues the frame that it completes, if any.
	function automatic void decode_edge(input logic lvl,
		input logic [askpfd_pkg::TICK_W-1:0] ticks, input logic tmo);
		tick_class_t             cls;
		askpfd_pkg::pulse_code_t code;
		logic                    data_bit;
		logic [7:0]              second;
		frame_result_t           r;

		// A timer overflow wins over whatever length the pulse had.
		if (tmo) begin
			pair_held = 1'b0;
			bits_seen = '0;
			return;
		end
		cls = tick_class(ticks);
		if (cls == TICK_NONE) begin
			pair_held = 1'b0;
			bits_seen = '0;
			return;
		end
		// A high new level means the pulse that just ended was low.
		if (cls == TICK_SHORT)
			code = lvl ? askpfd_pkg::PULSE_SHORT_LOW : askpfd_pkg::PULSE_SHORT_HIGH;
		else
			code = lvl ? askpfd_pkg::PULSE_LONG_LOW : askpfd_pkg::PULSE_LONG_HIGH;
		if (!pair_held) begin
			first_code = code;
			pair_held  = 1'b1;
			return;
		end
		if (first_code == askpfd_pkg::PULSE_SHORT_HIGH
				&& code == askpfd_pkg::PULSE_LONG_LOW) begin
			data_bit = 1'b0;
		end else if (first_code == askpfd_pkg::PULSE_LONG_HIGH
				&& code == askpfd_pkg::PULSE_SHORT_LOW) begin
			data_bit = 1'b1;
		end else begin
			pair_held = 1'b0;
			bits_seen = '0;
			return;
		end
		pair_held = 1'b0;
		shift_reg = {shift_reg[38:0], data_bit};
		bits_seen = bits_seen + 6'd1;
		if (bits_seen < FRAME_BITS)
			return;
		bits_seen = '0;
		r.host   = shift_reg[FRAME_BITS-1 -: 8];
		second   = shift_reg[FRAME_BITS-9 -: 8];
		r.level  = shift_reg[FRAME_BITS-17 -: 8];
		r.device = second[7:4];
		r.mode   = second[3:0];
		r.match  = (r.host == host_addr) && (r.device == dev_addr);
		if (r.match) begin
			act_mode  = r.mode;
			act_level = r.level;
		end
		r.act_mode  = act_mode;
		r.act_level = act_level;
		pending_frames.push_back(r);
	endfunction

	// Picks a tick count of the wanted class, often one at the edge of its window.
	// Returns 0 when no count of that class exists under the current windows.
	function automatic bit pick_ticks(input tick_class_t cls,
		output logic [askpfd_pkg::TICK_W-1:0] t);
		int n;
		int k;
		int sel;

		n = 0;
		t = '0;
		for (k = 0; k < 256; k++)
			if (tick_class(8'(k)) == cls)
				n++;
		if (n == 0)
			return 1'b0;
		case ($urandom_range(7))
			0: sel = 0;
			1: sel = n - 1;
			default: sel = $urandom_range(n - 1);
		endcase
		for (k = 0; k < 256; k++) begin
			if (tick_class(8'(k)) == cls) begin
				if (sel == 0) begin
					t = 8'(k);
					return 1'b1;
				end
				sel--;
			end
		end
		return 1'b0;
	endfunction

	// A frame can only be built when both a short and a long count exist.
	function automatic bit frames_possible();
		logic [askpfd_pkg::TICK_W-1:0] t;

		return pick_ticks(TICK_SHORT, t) && pick_ticks(TICK_LONG, t);
	endfunction

	// Offers one edge on the pulse channel and waits for its transfer. Valid is left
	// high on return, so that back-to-back edges keep it high without a glitch.
	task automatic send_edge(input logic lvl, input logic [askpfd_pkg::TICK_W-1:0] ticks,
		input logic tmo);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			pulse_ch.valid = 1'b0;
			@(negedge clk);
		end
		pulse_ch.valid       = 1'b1;
		pulse_ch.new_level   = lvl;
		pulse_ch.pulse_ticks = ticks;
		pulse_ch.timeout     = tmo;
		do
			@(posedge clk);
		while (pulse_ch.ready !== 1'b1);
		edges_sent++;
		decode_edge(lvl, ticks, tmo);
	endtask

	// Lowers valid, waits until every expected frame has arrived and lets the block settle.
	task automatic quiesce();
		@(negedge clk);
		pulse_ch.valid = 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [askpfd_pkg::CFG_IDX_W-1:0] idx,
		input logic [askpfd_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = data;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		case (idx)
			askpfd_pkg::REG_SHORT_MIN:      win.short_min = data;
			askpfd_pkg::REG_SHORT_MAX:      win.short_max = data;
			askpfd_pkg::REG_LONG_MIN:       win.long_min  = data;
			askpfd_pkg::REG_LONG_MAX:       win.long_max  = data;
			askpfd_pkg::REG_HOST_ADDRESS:   host_addr     = data;
			askpfd_pkg::REG_DEVICE_ADDRESS: dev_addr      = data[askpfd_pkg::NIBBLE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_windows(input logic [7:0] smin, input logic [7:0] smax,
		input logic [7:0] lmin, input logic [7:0] lmax);
		write_reg(askpfd_pkg::REG_SHORT_MIN, smin);
		write_reg(askpfd_pkg::REG_SHORT_MAX, smax);
		write_reg(askpfd_pkg::REG_LONG_MIN, lmin);
		write_reg(askpfd_pkg::REG_LONG_MAX, lmax);
	endtask

	task automatic set_address(input logic [7:0] host, input logic [7:0] dev);
		write_reg(askpfd_pkg::REG_HOST_ADDRESS, host);
		write_reg(askpfd_pkg::REG_DEVICE_ADDRESS, dev);
	endtask

	// One pulse of a bit. A corrupted pulse becomes a timeout, an out-of-window length,
	// the wrong level or the wrong length.
	task automatic send_half(input bit is_long, input logic lvl, input bit corrupt);
		logic [askpfd_pkg::TICK_W-1:0] t;

		void'(pick_ticks(is_long ? TICK_LONG : TICK_SHORT, t));
		if (!corrupt) begin
			send_edge(lvl, t, 1'b0);
			return;
		end
		case ($urandom_range(3))
			0: send_edge(lvl, t, 1'b1);
			1: begin
				if (pick_ticks(TICK_NONE, t))
					send_edge(lvl, t, 1'b0);
				else
					send_edge(lvl, t, 1'b1);
			end
			2: send_edge(~lvl, t, 1'b0);
			default: begin
				void'(pick_ticks(is_long ? TICK_SHORT : TICK_LONG, t));
				send_edge(lvl, t, 1'b0);
			end
		endcase
	endtask

	// A zero is a short high pulse and a long low one; a one is long high then short low.
	task automatic send_bit(input logic b, input bit bad_first, input bit bad_second);
		if (!b) begin
			send_half(1'b0, 1'b0, bad_first);
			send_half(1'b1, 1'b1, bad_second);
		end else begin
			send_half(1'b1, 1'b0, bad_first);
			send_half(1'b0, 1'b1, bad_second);
		end
	endtask

	// One frame with random content; its host and device each match this receiver about half the time.
	// Unless clean is set, it may lack the leading sync gap, carry one bad pulse or
	// run a few bits past its end.
	task automatic send_frame(input bit clean);
		logic [7:0]  host;
		logic [3:0]  dev;
		logic [3:0]  mode;
		logic [7:0]  level;
		logic [23:0] word;
		logic [askpfd_pkg::TICK_W-1:0] t;
		int bad_at;
		int extra;
		int i;

		host  = $urandom_range(1) ? host_addr : 8'($urandom_range(255));
		dev   = $urandom_range(1) ? dev_addr : 4'($urandom_range(15));
		mode  = 4'($urandom_range(15));
		level = 8'($urandom_range(255));
		word  = {host, dev, mode, level};
		bad_at = (!clean && $urandom_range(99) < 15) ? $urandom_range(2 * FRAME_BITS - 1) : -1;
		extra  = (!clean && $urandom_range(99) < 10) ? $urandom_range(1, 3) : 0;
		// The long gap before a frame shows up as a timer overflow on its first edge.
		if (clean || $urandom_range(99) < 80) begin
			t = 8'($urandom_range(255));
			send_edge(1'($urandom_range(1)), t, 1'b1);
		end
		for (i = 0; i < FRAME_BITS + extra; i++)
			send_bit(i < FRAME_BITS ? word[FRAME_BITS-1-i] : 1'($urandom_range(1)),
				bad_at == 2 * i, bad_at == 2 * i + 1);
	endtask

	// A short burst of unrelated edges: random lengths, classed lengths and timeouts.
	task automatic send_noise();
		logic [askpfd_pkg::TICK_W-1:0] t;
		int n;

		n = $urandom_range(1, 4);
		repeat (n) begin
			if ($urandom_range(1))
				t = 8'($urandom_range(255));
			else
				void'(pick_ticks(tick_class_t'($urandom_range(2)), t));
			send_edge(1'($urandom_range(1)), t, $urandom_range(99) < 20);
		end
	endtask

	// Mostly well-formed frames, the rest noise, until at least n more pulses have gone in.
	task automatic run_traffic(input int n);
		int start;

		start = edges_sent;
		while (edges_sent - start < n) begin
			if (frames_possible() && $urandom_range(99) < 80)
				send_frame(1'b0);
			else
				send_noise();
		end
	endtask

	// Window boundaries, timeouts and each kind of broken pair under the reset windows.
	// None of these edges completes a frame.
	task automatic test_edge_cases();
		send_edge(1'b0, win.long_min + 8'd4, 1'b1);
		send_edge(1'b0, 8'd0, 1'b0);
		send_edge(1'b1, 8'd255, 1'b0);
		send_edge(1'b0, win.short_min, 1'b0);
		// A zero bit built from the innermost short and long counts.
		send_edge(1'b0, win.short_min + 8'd1, 1'b0);
		send_edge(1'b1, win.long_min + 8'd1, 1'b0);
		// The upper short bound is outside the window and breaks the pair.
		send_edge(1'b0, win.short_max - 8'd1, 1'b0);
		send_edge(1'b1, win.short_max, 1'b0);
		// A one bit from the outermost long and short counts.
		send_edge(1'b0, win.long_max - 8'd1, 1'b0);
		send_edge(1'b1, win.short_max - 8'd1, 1'b0);
		send_edge(1'b0, win.long_min, 1'b0);
		send_edge(1'b0, win.long_max, 1'b0);
		// The level did not change between the two edges: two short high pulses.
		send_edge(1'b0, win.short_min + 8'd2, 1'b0);
		send_edge(1'b0, win.short_min + 8'd3, 1'b0);
		send_edge(1'b0, win.short_min + 8'd2, 1'b0);
		// A long high pulse breaks the pair held above; a timeout then arrives with no first half held.
		send_edge(1'b0, win.long_min + 8'd10, 1'b0);
		send_edge(1'b1, win.long_min + 8'd10, 1'b1);
		// Pairs in the wrong order: long low then long high, short low then long low.
		send_edge(1'b1, win.long_min + 8'd5, 1'b0);
		send_edge(1'b0, win.long_min + 8'd5, 1'b0);
		send_edge(1'b1, win.short_min + 8'd1, 1'b0);
		send_edge(1'b1, win.long_min + 8'd1, 1'b0);
		// The count between the two windows belongs to neither.
		send_edge(1'b1, win.short_max + 8'd1, 1'b0);
		send_edge(1'b1, 8'd128, 1'b1);
		send_edge(1'b0, 8'd255, 1'b1);
	endtask

	// Random frames and noise under the current idling settings.
	task automatic test_frames(input int gap, input int stall, input int n);
		gap_pct   = gap;
		stall_pct = stall;
		run_traffic(n);
	endtask

	// Walks the registers through several settings, the extremes among them, with
	// a little traffic under each. Every write happens with the block idle.
	task automatic test_register_settings();
		gap_pct   = 10;
		stall_pct = 10;
		// Full-range short window: every count from 1 to 254 is short and no bit forms.
		quiesce();
		set_windows(8'd0, 8'd255, 8'd0, 8'd255);
		set_address(8'd255, 8'hFF);
		run_traffic(40);
		// All bounds at zero: nothing is ever in a window.
		quiesce();
		set_windows(8'd0, 8'd0, 8'd0, 8'd0);
		set_address(8'd0, 8'd0);
		run_traffic(30);
		// Overlapping windows: the overlap counts as short.
		quiesce();
		set_windows(8'd10, 8'd40, 8'd20, 8'd80);
		set_address(8'hA5, 8'h37);
		run_traffic(80);
		// Single-count windows; the upper bits of the device write are dropped.
		quiesce();
		set_windows(8'd9, 8'd11, 8'd200, 8'd202);
		set_address(8'd0, 8'hF0);
		run_traffic(60);
		// Writes past the last register must leave the decoder untouched.
		quiesce();
		write_reg(REG_SPARE_LO, 8'($urandom_range(255)));
		write_reg(REG_SPARE_HI, 8'($urandom_range(255)));
		run_traffic(50);
		// Windows at the top of the tick range.
		quiesce();
		set_windows(8'd100, 8'd150, 8'd160, 8'd255);
		set_address(8'd255, 8'h0F);
		run_traffic(60);
		// A working setting for the phases that follow.
		quiesce();
		set_windows(8'd3, 8'd20, 8'd25, 8'd90);
		set_address(8'h3C, 8'h09);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering clean
	// frames, so the result stage fills and the pulse input must stall.
	task automatic test_backpressure();
		gap_pct   = 0;
		stall_pct = 0;
		hold_left = HOLD_CYCLES;
		repeat (3) send_frame(1'b1);
	endtask

	// Receiver: ready changes at the falling edge. A pending hold-off is counted down
	// here, one cycle at a time, before random stalls are allowed again.
	initial begin
		frame_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				frame_ch.ready = 1'b0;
				hold_left--;
			end else begin
				frame_ch.ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic check_field(input string name, input int expected, input int actual);
		if (expected != actual) begin
			$display("%0t: frame field %s mismatch: expected 0x%0h, actual 0x%0h", $time, name,
				expected, actual);
			errors++;
		end
	endtask

	// Each frame transfer is matched against the oldest expected frame.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: frame transfer with none expected: expected nothing, actual %h",
					$time, {frame_ch.frame_host, frame_ch.frame_device, frame_ch.frame_mode,
					frame_ch.frame_level});
				errors++;
			end else begin
				want = pending_frames.pop_front();
				check_field("frame_host", want.host, frame_ch.frame_host);
				check_field("frame_device", want.device, frame_ch.frame_device);
				check_field("frame_mode", want.mode, frame_ch.frame_mode);
				check_field("frame_level", want.level, frame_ch.frame_level);
				check_field("address_match", want.match, frame_ch.address_match);
				check_field("action_mode", want.act_mode, frame_ch.action_mode);
				check_field("action_level", want.act_level, frame_ch.action_level);
			end
		end
	end

	// Test sequence: reset once, then each test in turn, then a drain and the verdict.
	initial begin
		errors      = 0;
		edges_sent  = 0;
		cycle_count = 0;
		gap_pct     = 0;
		stall_pct   = 0;
		hold_left   = 0;
		arst_n      = 1'b0;
		pulse_ch.valid       = 1'b0;
		pulse_ch.new_level   = 1'b0;
		pulse_ch.pulse_ticks = '0;
		pulse_ch.timeout     = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		reset_decoder();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_edge_cases();
		test_frames(0, 0, 150);
		test_register_settings();
		test_frames(79, 0, 200);
		test_frames(0, 79, 200);
		test_frames(28, 28, 200);
		test_backpressure();
		test_frames(20, 20, 50);

		quiesce();
		if (errors == 0)
			$display("ask_pulse_frame_decoder_tb OK");
		else
			$display("ask_pulse_frame_decoder_tb NOT OK");
		$finish;
	end

endmodule
